>>> hw/rtl/mrt_pkg.sv
// Shared types, request codes and status codes of the masked route table.
package mrt_pkg;

   // Default number of route slots, one compare cell for each slot.
   localparam int TABLE_ENTRIES_DEFAULT = 16;

   // Request codes.
   localparam logic [1:0] REQ_LOOKUP  = 2'd0;
   localparam logic [1:0] REQ_INSTALL = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;

   // Status codes.
   localparam logic [2:0] ST_HIT             = 3'd0;
   localparam logic [2:0] ST_MISS            = 3'd1;
   localparam logic [2:0] ST_INSTALLED       = 3'd2;
   localparam logic [2:0] ST_DUPLICATE       = 3'd3;
   localparam logic [2:0] ST_FULL_OR_CLEARED = 3'd4;

   // Only an IPv4 address of this length in bytes can hit.
   localparam logic [4:0] IPV4_ADDR_LEN = 5'd4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] address;
      logic [31:0] net_mask;
      logic [3:0]  interface_id;
      logic [4:0]  addr_len;
      logic        is_ipv4;
   } mrt_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] out_interface;
      logic [3:0] match_index;
   } mrt_rsp_type;

   // What travels from cell to cell: the request as it stands and, once
   // some cell has settled it, its answer.
   typedef struct packed {
      logic        active;
      logic [1:0]  op;
      logic        done;
      logic [31:0] key;
      logic [31:0] mask;
      logic [3:0]  port;
      mrt_rsp_type rsp;
   } mrt_token_type;

endpackage

>>> hw/rtl/masked_route_table_first_match_core.sv
// Top level of the masked route table with first-match lookup in insertion order.
//
// The table is a row of TABLE_ENTRIES compare cells, one route slot in each,
// filled in order from slot 0. An accepted item enters the first cell and is
// handed one cell further at every clock edge; the first cell that settles it
// (a lookup hit, a duplicate network on install, or the first empty slot on
// install) records the answer, and the cells after it only pass it along. An
// item passes through every cell register on its way to the result register,
// and the table works on one item at a time: the next item is taken in the
// cycle after the result has been taken. A lookup that is not IPv4 or whose
// length is not four bytes misses, a clear empties the table at once, and an
// install that meets a full table is dropped and answers table full. Route
// slots need no clearing after reset, since the route count is reset to zero.
module masked_route_table_first_match_core import mrt_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  mrt_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output mrt_rsp_type rsp_data
);

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic                 busy_ff, busy_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mrt_rsp_type          rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 req_accept;
   logic                 rsp_take;
   mrt_token_type        head_tok;
   mrt_token_type        tail_tok;
   mrt_rsp_type          tail_rsp;
   mrt_token_type        chain_tok [TABLE_ENTRIES+1];
   logic [TABLE_ENTRIES-1:0] tok_active;

   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;

   // Build the token for the first cell. Requests that need no table walk
   // are settled here and simply ride along the row.
   always_comb begin
      head_tok        = '0;
      head_tok.active = req_accept;
      head_tok.op     = req_data.req_type;
      head_tok.key    = req_data.address;
      head_tok.mask   = req_data.net_mask;
      head_tok.port   = req_data.interface_id;
      unique case (req_data.req_type)
         REQ_LOOKUP: begin
            if (!req_data.is_ipv4 || (req_data.addr_len != IPV4_ADDR_LEN)) begin
               head_tok.done       = 1'b1;
               head_tok.rsp.status = ST_MISS;
            end
         end
         REQ_INSTALL: begin
            head_tok.key = req_data.address & req_data.net_mask;
         end
         REQ_CLEAR: begin
            head_tok.done       = 1'b1;
            head_tok.rsp.status = ST_FULL_OR_CLEARED;
         end
         default: begin
            head_tok.done       = 1'b1;
            head_tok.rsp.status = ST_MISS;
         end
      endcase
   end

   assign chain_tok[0] = head_tok;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : gen_cell
      mrt_cell #(
         .CELL_INDEX (g),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .tok_prev    (chain_tok[g]),
         .route_count (count_ff),
         .tok_out     (chain_tok[g+1])
      );
      assign tok_active[g] = chain_tok[g+1].active;
   end

   assign tail_tok = chain_tok[TABLE_ENTRIES];

   // A token that leaves the row unsettled is a lookup miss, or an install
   // that found neither a duplicate nor an empty slot.
   always_comb begin
      tail_rsp = tail_tok.rsp;
      if (!tail_tok.done) begin
         tail_rsp = '0;
         if (tail_tok.op == REQ_INSTALL) begin
            tail_rsp.status = ST_FULL_OR_CLEARED;
         end else begin
            tail_rsp.status = ST_MISS;
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept && (req_data.req_type == REQ_CLEAR)) begin
         count_in = '0;
      end else if (tail_tok.active && (tail_rsp.status == ST_INSTALLED)) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (rsp_take) begin
         busy_in = 1'b0;
      end
      if (tail_tok.active) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = tail_rsp;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The route count never passes the number of slots.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("route count exceeds the table size");

   // Only one item is ever on its way along the cell row.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_active))
      else $error("more than one item in the cell row");

   // A waiting result belongs to the item in hand, so the input stays stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> busy_ff)
      else $error("result waiting while the input is open");

   // No result may arrive while an earlier one still waits.
   assert property (@(posedge clock) disable iff (reset)
      tail_tok.active |-> !rsp_valid_ff)
      else $error("result overwritten before it was taken");

endmodule

>>> hw/rtl/mrt_cell.sv
// One route slot of the table with its compare logic and a token register.
module mrt_cell import mrt_pkg::*; #(
   parameter int CELL_INDEX = 0,
   parameter int CNT_W      = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mrt_token_type        tok_prev,
   input  logic [CNT_W-1:0]     route_count,
   output mrt_token_type        tok_out
);

   localparam logic [CNT_W-1:0] SLOT     = CNT_W'(CELL_INDEX);
   localparam logic [3:0]       SLOT_LOW = 4'(CELL_INDEX);

   mrt_token_type tok_ff, tok_in;
   logic [31:0]   network_ff, network_in;
   logic [31:0]   mask_ff, mask_in;
   logic [3:0]    port_ff, port_in;
   logic          entry_valid;
   logic          write_en;

   // Slots below the route count are filled, and they are filled in order.
   assign entry_valid = (SLOT < route_count);

   always_comb begin
      tok_in   = tok_prev;
      write_en = 1'b0;
      if (tok_prev.active && !tok_prev.done) begin
         if (tok_prev.op == REQ_LOOKUP) begin
            if (entry_valid && ((tok_prev.key & mask_ff) == network_ff)) begin
               tok_in.done              = 1'b1;
               tok_in.rsp.status        = ST_HIT;
               tok_in.rsp.out_interface = port_ff;
               tok_in.rsp.match_index   = SLOT_LOW;
            end
         end else if (tok_prev.op == REQ_INSTALL) begin
            if (entry_valid && (network_ff == tok_prev.key)) begin
               tok_in.done       = 1'b1;
               tok_in.rsp.status = ST_DUPLICATE;
            end else if (!entry_valid) begin
               // The first empty slot the token meets is the append slot.
               write_en                = 1'b1;
               tok_in.done             = 1'b1;
               tok_in.rsp.status       = ST_INSTALLED;
               tok_in.rsp.match_index  = SLOT_LOW;
            end
         end
      end
   end

   assign network_in = write_en ? tok_prev.key  : network_ff;
   assign mask_in    = write_en ? tok_prev.mask : mask_ff;
   assign port_in    = write_en ? tok_prev.port : port_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      network_ff <= network_in;
      mask_ff    <= mask_in;
      port_ff    <= port_in;
   end

   assign tok_out = tok_ff;

endmodule
